### rtl/core/nsr_pkg.sv
// nsr_pkg: constants, payload structs, status codes and sequencer states
// for the fixed-point newton square root block; no dependencies
package nsr_pkg;

  localparam int MAX_ITER   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;

  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ITERS_W   = 7;
  localparam int TOL_W     = 32;
  localparam int ITER_W    = $clog2(MAX_ITER + 1);
  localparam int DIV_CNT_W = $clog2(WORD_WIDTH);
  localparam int PROD_W    = WORD_WIDTH + TOL_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2147484);

  typedef enum logic [STATUS_W-1:0] {
    STAT_CONVERGED  = 2'd0,
    STAT_LIMIT      = 2'd1,
    STAT_ZERO_GUESS = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] radicand;
    logic [DATA_W-1:0] initial_guess;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  root;
    status_t            status;
    logic [ITERS_W-1:0] iterations;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DIV,
    ST_UPD,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [WORD_WIDTH-1:0] dividend;
    logic [WORD_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [WORD_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/nsr_div.sv
// nsr_div: iterative restoring divider, quotient = floor(x * 2^FRAC_BITS / g)
// saturated to WORD_WIDTH bits, one quotient bit per cycle; uses nsr_pkg
module nsr_div
  import nsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int W  = WORD_WIDTH;
  localparam int SH = WORD_WIDTH - FRAC_BITS;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         quo_r, quo_nxt;
  logic [W-1:0]         dvs_r, dvs_nxt;

  logic [W:0]  shifted;
  logic [W:0]  trial;
  logic        fits;
  logic        sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  // quo_r shifts the low dividend bits out the top and quotient bits in below
  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    fits     = !trial[W];
    // quotient overflows exactly when x >= g * 2^(W - FRAC_BITS)
    sat      = {{SH{1'b0}}, req.dividend} >= {req.divisor, {SH{1'b0}}};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      dvs_nxt = req.divisor;
      if (sat) begin
        quo_nxt  = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = W'(req.dividend >> SH);
        quo_nxt  = W'({req.dividend, {FRAC_BITS{1'b0}}});
        cnt_nxt  = DIV_CNT_W'(W - 1);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? trial[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("divider started while busy");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == '0 && !req.start |=> done_r && !busy_r)
    else $error("divider missed its done pulse");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still stepping");

  a_sat_fast: assert property (@(posedge clk) disable iff (!rst_n)
    req.start && sat |=> done_r && quo_r == '1)
    else $error("saturated quotient not returned");

endmodule

### rtl/core/newton_square_root_top.sv
// newton square root: one Newton (Heron) step per pass of a shared divider
// a zero guess goes straight to the result; else each step passes ST_ISSUE, ST_DIV, ST_UPD
// and ST_CHK, for at most MAX_ITER steps, and a saturated quotient skips the bit-serial divide;
// the restoring divide takes most of the time; one item in work at a time, the next
// input transfer comes in the cycle after the result is loaded, later if out_stall holds it
// synchronous active-low reset clears control and loads the tolerance reset value
module newton_square_root_top
  import nsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [TOL_W-1:0]  cfg_wr_data
);

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0] NEXT_SAT = {1'b0, {(W-1){1'b1}}};

  state_t             state_r, state_nxt;
  logic [TOL_W-1:0]   tol_r;
  logic [W-1:0]       x_r, x_nxt;
  logic [W-1:0]       g_r, g_nxt;
  logic [W-1:0]       next_r, next_nxt;
  logic [W-1:0]       diff_r, diff_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [W:0]         sum_w;
  logic [W-1:0]       guess_in;
  logic               in_xfer;

  nsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
    end
    x_r        <= x_nxt;
    g_r        <= g_nxt;
    next_r     <= next_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    iter_r     <= iter_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign guess_in = W'(in_data.initial_guess);
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    g_nxt         = g_r;
    next_nxt      = next_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    iter_nxt      = iter_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    div_req.start    = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = g_r;

    sum_w = {1'b0, g_r} + {1'b0, div_rsp.quotient};

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt    = W'(in_data.radicand);
          g_nxt    = guess_in;
          iter_nxt = '0;
          if (guess_in == '0) begin
            res_nxt.root       = '0;
            res_nxt.status     = STAT_ZERO_GUESS;
            res_nxt.iterations = '0;
            state_nxt          = ST_DONE;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // saturated sum halves to the all-ones value shifted right
          next_nxt  = sum_w[W] ? NEXT_SAT : sum_w[W:1];
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        diff_nxt  = (next_r >= g_r) ? next_r - g_r : g_r - next_r;
        prod_nxt  = PROD_W'(tol_r) * PROD_W'(next_r);
        iter_nxt  = iter_r + 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        res_nxt.root       = DATA_W'(next_r);
        res_nxt.iterations = ITERS_W'(iter_r);
        // exact test: diff * 2^32 < tol * next
        if (next_r == '0 || {diff_r, {TOL_W{1'b0}}} < prod_r) begin
          res_nxt.status = STAT_CONVERGED;
          state_nxt      = ST_DONE;
        end else if (iter_r == ITER_W'(MAX_ITER)) begin
          res_nxt.status = STAT_LIMIT;
          state_nxt      = ST_DONE;
        end else begin
          g_nxt     = next_r;
          state_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy with no item in work");

  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK |-> iter_r <= ITER_W'(MAX_ITER) && iter_r != '0)
    else $error("step count out of range");

  a_zero_guess: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && guess_in == '0 |=> state_r == ST_DONE)
    else $error("zero guess not short-cut");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == STAT_LIMIT |->
      out_data_r.iterations == ITERS_W'(MAX_ITER))
    else $error("limit status with wrong step count");

endmodule
